// File: hw/rtl/sott_pkg.sv
// ----------------------------------------------------------------------------
// sott_pkg
// Shared types and codes for the span owner token table.
// ----------------------------------------------------------------------------
package sott_pkg;

    localparam int unsigned GEN_W   = 32;
    localparam int unsigned OWNER_W = 6;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned ENTRY_W = GEN_W + CODE_W;
    localparam int unsigned S_DATA_W = 104;  // 102 payload bits padded to bytes
    localparam int unsigned M_DATA_W = 48;   // 42 payload bits padded to bytes

    typedef enum logic [1:0] {
        K_CLAIM  = 2'd0,
        K_LOOKUP = 2'd1,
        K_REHOME = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_REJECT = 3'd0,
        ST_DONE   = 3'd1,
        ST_SAME   = 3'd2,
        ST_OTHER  = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic {
        CFG_ARENA_BASE  = 1'b0,
        CFG_OWNER_LIMIT = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [CODE_W-1:0] code;
    } t_entry;

endpackage

// File: hw/rtl/span_owner_token_table_unit.sv
// Flow: one transaction at a time (accept, table read, update). Its entry is read
//   in S_LOOK; the result is registered in S_EXEC once no older result waits on
//   m_tready. The single table port is read in S_LOOK and written in S_EXEC.
// Reset: synchronous, active low. Afterwards the table is swept to empty,
//   one entry a cycle through all SPAN_COUNT entries, with s_tready low; config
//   writes are taken during the sweep.
// ----------------------------------------------------------------------------
// span_owner_token_table_unit
// Per-span ownership table: claim, lookup, rehome and clear-if-match on an
// owner/generation token held in a single-port synchronous memory.
// ----------------------------------------------------------------------------
module span_owner_token_table_unit #(
    parameter int unsigned SPAN_COUNT = 4096,
    parameter int unsigned SPAN_SHIFT = 16,
    parameter int unsigned MAX_OWNERS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sott_pkg::ADDR_W-1:0]   i_cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // address[63:0], owner_num[69:64], generation[101:70], zero pad
    input  logic [sott_pkg::S_DATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], found_owner[8:3], found_generation[40:9], is_local[41], pad
    output logic [sott_pkg::M_DATA_W-1:0] m_tdata
);
    import sott_pkg::*;

    localparam int unsigned IDX_W = $clog2(SPAN_COUNT);

    t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_arena_base;
    logic [CODE_W-1:0]  r_owner_lim;
    logic [IDX_W-1:0]   r_clr_idx;

    // held input transaction
    t_kind              r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic [OWNER_W-1:0] r_oid;
    logic [GEN_W-1:0]   r_gen;

    // table read results
    logic [IDX_W-1:0]   r_idx;
    logic               r_in_arena;
    t_entry             r_rd_data;

    t_entry             r_table [SPAN_COUNT];

    // output register
    logic               r_m_valid;
    t_status            r_status;
    logic [OWNER_W-1:0] r_fown;
    logic [GEN_W-1:0]   r_fgen;
    logic               r_local;

    logic               w_accept;
    logic               w_exec_go;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_idx;
    t_entry             w_wr_data;

    // span mapping
    logic [ADDR_W-1:0]  w_diff;
    logic [ADDR_W-1:0]  w_off;
    logic               w_in_arena;

    // operation
    logic [8:0]         w_nown;
    t_entry             w_token;
    logic               w_tok_ok;
    logic               w_entry_ok;
    t_status            n_status;
    logic [OWNER_W-1:0] n_fown;
    logic [GEN_W-1:0]   n_fgen;
    logic               n_local;
    logic               w_upd;
    t_entry             w_upd_data;

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == IDX_W'(SPAN_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_tvalid) n_state = S_LOOK;
            S_LOOK:  n_state = S_EXEC;
            S_EXEC:  if (!r_m_valid || m_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        w_exec_go = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_idx  = r_idx;
        w_wr_data = w_upd_data;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_idx  = r_clr_idx;
                w_wr_data = '0;
            end
            S_IDLE:  s_tready = 1'b1;
            S_LOOK:  ;
            S_EXEC: begin
                w_exec_go = !r_m_valid || m_tready;
                w_wr_en   = w_exec_go && w_upd;
            end
            default: ;
        endcase
    end

    assign w_accept = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_arena_base <= '0;
            r_owner_lim  <= CODE_W'(1);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ARENA_BASE:  r_arena_base <= i_cfg_wdata;
                    CFG_OWNER_LIMIT: r_owner_lim  <= i_cfg_wdata[CODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(s_tuser);
            r_addr <= s_tdata[ADDR_W-1:0];
            r_oid  <= s_tdata[ADDR_W +: OWNER_W];
            r_gen  <= s_tdata[ADDR_W+OWNER_W +: GEN_W];
        end
    end

    // ------------------------------------------------------------------
    // Span index and table access
    // ------------------------------------------------------------------
    assign w_diff     = r_addr - r_arena_base;
    assign w_off      = w_diff >> SPAN_SHIFT;
    assign w_in_arena = (r_arena_base != '0) && (r_addr != '0) &&
                        (r_addr >= r_arena_base) && (w_off < ADDR_W'(SPAN_COUNT));

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_rd_data  <= r_table[w_off[IDX_W-1:0]];
            r_idx      <= w_off[IDX_W-1:0];
            r_in_arena <= w_in_arena;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_table[w_wr_idx] <= w_wr_data;
    end

    // ------------------------------------------------------------------
    // Operation on the fetched entry
    // ------------------------------------------------------------------
    assign w_nown = ({2'b00, r_owner_lim} > 9'(MAX_OWNERS)) ? 9'(MAX_OWNERS)
                                                             : {2'b00, r_owner_lim};
    assign w_token.gen  = r_gen;
    assign w_token.code = CODE_W'({1'b0, r_oid}) + CODE_W'(1);
    assign w_tok_ok     = ({3'b000, r_oid} < w_nown) && (r_gen != '0);
    assign w_entry_ok   = (r_rd_data.code != '0) && ({2'b00, r_rd_data.code} <= w_nown) &&
                          (r_rd_data.gen != '0);

    always_comb begin
        n_status   = ST_REJECT;
        n_fown     = '0;
        n_fgen     = '0;
        n_local    = 1'b0;
        w_upd      = 1'b0;
        w_upd_data = w_token;
        if (r_in_arena) begin
            if (r_kind == K_LOOKUP) begin
                if (w_entry_ok) begin
                    n_status = ST_DONE;
                    n_fown   = OWNER_W'(r_rd_data.code - CODE_W'(1));
                    n_fgen   = r_rd_data.gen;
                    n_local  = (n_fown == r_oid);
                end else begin
                    n_status = ST_EMPTY;
                end
            end else if (w_tok_ok) begin
                case (r_kind)
                    K_CLAIM: begin
                        if (r_rd_data == '0) begin
                            w_upd    = 1'b1;
                            n_status = ST_DONE;
                        end else begin
                            n_status = (r_rd_data == w_token) ? ST_SAME : ST_OTHER;
                        end
                    end
                    K_REHOME: begin
                        w_upd    = 1'b1;
                        n_status = ST_DONE;
                    end
                    default: begin
                        // clear only when the stored token matches exactly
                        if (r_rd_data == w_token) begin
                            w_upd      = 1'b1;
                            w_upd_data = '0;
                            n_status   = ST_DONE;
                        end else begin
                            n_status = (r_rd_data == '0) ? ST_EMPTY : ST_OTHER;
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_exec_go) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_status <= n_status;
            r_fown   <= n_fown;
            r_fgen   <= n_fgen;
            r_local  <= n_local;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'b000000, r_local, r_fgen, r_fown, r_status};

endmodule

// File: hw/rtl/sott_checker.sv
// ----------------------------------------------------------------------------
// sott_checker
// Port-level checks for the span owner token table, bound to the top level.
// ----------------------------------------------------------------------------
module sott_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sott_pkg::M_DATA_W-1:0] m_tdata
);
    import sott_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_EMPTY)
        else $error("status code out of range");

    // found fields carry data only for a matched lookup
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[2:0] != ST_DONE) |-> m_tdata[41:3] == '0)
        else $error("found fields set on a non-matching result");

    // one transaction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("ports not quiet after reset");

endmodule

bind span_owner_token_table_unit sott_checker u_sott_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
